[src/swm_pkg.sv]
`default_nettype none
package swm_pkg;

  localparam int WIN_MAX  = 64;
  localparam int AGE_W    = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int CNT_W    = 7;
  localparam int SAMPLE_W = 32;
  localparam int MED_W    = SAMPLE_W + 1;
  localparam int OUT_TW   = ((MED_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] WS_RESET = CNT_W'(3);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // One slot of the sorted row: value plus its age in items.
  typedef struct packed {
    logic                       vld;
    logic [AGE_W-1:0]           age;
    logic signed [SAMPLE_W-1:0] val;
  } cell_t;

  // Window length actually used: zero means one, large values saturate.
  function automatic logic [CNT_W-1:0] eff_k(input logic [CNT_W-1:0] ws);
    logic [CNT_W-1:0] k;
    k = ws;
    if (ws == '0) k = CNT_W'(1);
    else if (ws > CNT_W'(WIN_MAX)) k = CNT_W'(WIN_MAX);
    return k;
  endfunction

endpackage
`default_nettype wire

[src/swm_cell.sv]
`default_nettype none
module swm_cell (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              en,
  input  wire                              clear,
  input  wire                              rm_en,
  input  wire [swm_pkg::AGE_W-1:0]         k_m1,
  input  wire signed [swm_pkg::SAMPLE_W-1:0] sample,
  input  swm_pkg::cell_t                   left_i,
  input  swm_pkg::cell_t                   own_i,
  input  swm_pkg::cell_t                   right_i,
  input  wire                              rm_seen_i,
  output logic                             rm_seen_o,
  output swm_pkg::cell_t                   cell_o
);
  import swm_pkg::*;

  cell_t cell_r, cell_nxt;
  cell_t c_src, p_src;
  logic  rm;

  assign rm        = own_i.vld && rm_en && (own_i.age == k_m1);
  assign rm_seen_o = rm_seen_i | rm;

  // c_src: what sits at this slot once the outgoing item is squeezed out,
  // p_src: what sits one slot to the left.
  always_comb begin
    c_src    = (rm_seen_i || rm) ? right_i : own_i;
    p_src    = rm_seen_i ? own_i : left_i;
    cell_nxt = c_src;
    if (c_src.vld && (c_src.val <= sample)) begin
      cell_nxt.age = c_src.age + AGE_W'(1);
    end else if (p_src.vld && (p_src.val > sample)) begin
      cell_nxt     = p_src;
      cell_nxt.age = p_src.age + AGE_W'(1);
    end else if (p_src.vld) begin
      cell_nxt.vld = 1'b1;
      cell_nxt.age = '0;
      cell_nxt.val = sample;
    end else begin
      cell_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r.vld <= cell_nxt.vld;
    end
    if (en) begin
      cell_r.age <= cell_nxt.age;
      cell_r.val <= cell_nxt.val;
    end
  end

  assign cell_o = cell_r;

endmodule
`default_nettype wire

[src/swm_median.sv]
`default_nettype none
module swm_median (
  input  wire                          clk,
  input  wire                          load,
  input  swm_pkg::cell_t               cells_i [swm_pkg::WIN_MAX],
  input  wire [swm_pkg::CNT_W-1:0]     k,
  output logic signed [swm_pkg::MED_W-1:0] med_o
);
  import swm_pkg::*;

  logic [AGE_W-1:0] idx_hi, idx_lo;
  logic signed [MED_W-1:0] med_r, med_nxt;

  // Odd window: middle slot twice; even: the two middle slots.
  always_comb begin
    idx_hi  = AGE_W'(k >> 1);
    idx_lo  = k[0] ? idx_hi : idx_hi - AGE_W'(1);
    med_nxt = MED_W'(cells_i[idx_lo].val) + MED_W'(cells_i[idx_hi].val);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      med_r <= med_nxt;
    end
  end

  assign med_o = med_r;

endmodule
`default_nettype wire

[src/sliding_window_median.sv]
// Running median over a sliding window of signed 32-bit samples.
//
// Input channel in_*: one sample per item in in_tdata, in_tuser set marks
// the first sample of a new sequence and empties the window before it.
// Output channel out_*: one item per sample once the window holds K
// samples, carrying the sum of the two middle values (twice the median),
// sign-extended to 33 bits in a 40-bit tdata.
// cfg_we/cfg_wdata set the window length K (0 acts as 1, above 64 as 64)
// and empty the window; write only while no item is in flight.
//
// Throughput: one item per cycle while the receiver takes results. A row
// of 64 compare-and-shift slots registers the sorted window when a sample
// is accepted; once the output register is free, the middle slots are
// picked and added into it.
// Reset empties the window and sets K to 3. When the receiver stalls,
// the output register holds its item; the block keeps taking samples
// until a second result is pending behind it, then drops in_tready.
`default_nettype none
module sliding_window_median (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] sample
  input  wire  [0:0]  in_tuser,   // [0] first
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [32:0] median_doubled, [39:33] zero
  input  wire         cfg_we,
  input  wire  [6:0]  cfg_wdata
);
  import swm_pkg::*;

  logic [CNT_W-1:0] ws_r, fill_r, fill_nxt, fill_eff, k;
  logic             pend_r, out_vld_r, can_load, accept, full, has_result;
  logic [AGE_W-1:0] k_m1;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [MED_W-1:0]    med;
  logic             flush;
  cell_t            cell_q [WIN_MAX];
  cell_t            view   [WIN_MAX+2];
  logic [WIN_MAX:0] rm_chain;
  logic [WIN_MAX-1:0] vld_vec;

  assign sample   = $signed(in_tdata);
  assign k        = eff_k(ws_r);
  assign k_m1     = AGE_W'(k - CNT_W'(1));
  assign can_load = !out_vld_r || out_tready;
  assign in_tready = !pend_r || can_load;
  assign accept   = in_tvalid && in_tready;
  assign flush    = in_tuser[0];

  always_comb begin
    fill_eff   = flush ? '0 : fill_r;
    full       = (fill_eff == k);
    fill_nxt   = full ? k : fill_eff + CNT_W'(1);
    has_result = (fill_nxt == k);
  end

  // Slot row seen by the cells: a floor entry on the left, empty on the right.
  always_comb begin
    view[0].vld = 1'b1;
    view[0].age = '0;
    view[0].val = SAMPLE_MIN;
    for (int i = 0; i < WIN_MAX; i++) begin
      view[i+1]     = cell_q[i];
      view[i+1].vld = cell_q[i].vld && !flush;
      vld_vec[i]    = cell_q[i].vld;
    end
    view[WIN_MAX+1]     = view[0];
    view[WIN_MAX+1].vld = 1'b0;
  end

  assign rm_chain[0] = 1'b0;

  for (genvar g = 0; g < WIN_MAX; g++) begin : g_cell
    swm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (accept),
      .clear     (cfg_we),
      .rm_en     (full),
      .k_m1      (k_m1),
      .sample    (sample),
      .left_i    (view[g]),
      .own_i     (view[g+1]),
      .right_i   (view[g+2]),
      .rm_seen_i (rm_chain[g]),
      .rm_seen_o (rm_chain[g+1]),
      .cell_o    (cell_q[g])
    );
  end

  swm_median u_median (
    .clk     (clk),
    .load    (pend_r && can_load),
    .cells_i (cell_q),
    .k       (k),
    .med_o   (med)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r      <= WS_RESET;
      fill_r    <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ws_r   <= cfg_wdata;
        fill_r <= '0;
      end else if (accept) begin
        fill_r <= fill_nxt;
      end
      if (accept) begin
        pend_r <= has_result;
      end else if (can_load) begin
        pend_r <= 1'b0;
      end
      if (can_load) begin
        out_vld_r <= pend_r;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TW-MED_W){1'b0}}, med};

  a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(fill_r))
    else $error("fill count differs from occupied slots");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= k)
    else $error("fill count above window length");

  a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !can_load) |-> !in_tready)
    else $error("input taken while a result is blocked");

  a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && can_load && !cfg_we) |=> out_vld_r)
    else $error("pending result lost");

endmodule
`default_nettype wire
